[hdl/lcr_pkg.sv]
`default_nettype none
package lcr_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 64;
	localparam int unsigned MAX_HEIGHT_DEF = 64;

	localparam int unsigned CFG_W   = 7;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned COUNT_W = 13;

	typedef enum logic [1:0] {
		CELL_EMPTY  = 2'b00,
		CELL_WALL   = 2'b01,
		CELL_MARK_A = 2'b10,
		CELL_MARK_B = 2'b11
	} cell_t;

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV_S_GO,
		ST_DIV_S_WAIT,
		ST_DIV_E_GO,
		ST_DIV_E_WAIT,
		ST_DECIDE,
		ST_DRAW,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_POP_RD,
		ST_POP_WAIT,
		ST_NB_SEL,
		ST_NB_CHK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                start;
		logic [POS_W-1:0]    dividend;
		logic [CFG_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [POS_W-1:0]    quo;
		logic [CFG_W-1:0]    rem;
	} div_rsp_t;

endpackage
`default_nettype wire

[hdl/lcr_ram.sv]
`default_nettype none
module lcr_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[hdl/lcr_div.sv]
`default_nettype none
module lcr_div
	import lcr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	// Restoring division, one quotient bit per cycle.
	logic [POS_W-1:0] quo_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] dvs_q;
	logic [3:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CFG_W:0]   trial;

	assign trial = {rem_q, quo_q[POS_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(POS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= CFG_W'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[POS_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CFG_W-1:0];
				quo_q <= {quo_q[POS_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

[hdl/line_draw_region_counter.sv]
`default_nettype none
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid / in_stall   | start_position, end_position
// output  | out       | out_valid / out_stall | open_regions, bad_line
// config  | in        | cfg_wen               | cfg_index, cfg_data
//
// One line is decoded by two passes of the shared serial divider and one
// decision state, then drawn at one cell per cycle; then every cell is scanned
// and each open cell found is filled, as the cell memory is read, and written,
// once per visited neighbour.
// After reset a clearing pass writes every cell of the grid memory, one per
// cycle, while no input beat is taken. The result waits in an output register,
// so a new line is accepted while an earlier result is still stalled.
module line_draw_region_counter
	import lcr_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wen,
	input  wire logic               cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [POS_W-1:0]   start_position,
	input  wire logic [POS_W-1:0]   end_position,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [COUNT_W-1:0]      open_regions,
	output logic                    bad_line
);

	// Cells are addressed as {row, column}, so a step down is a row increment.
	localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned AW    = RW + CW;
	localparam int unsigned CELLS = 1 << AW;

	state_t state_q, state_d;

	logic [CFG_W-1:0] width_raw_q, height_raw_q;
	logic [CFG_W-1:0] w, h;
	logic [2*CFG_W-1:0] total;

	logic [POS_W-1:0] s_q, e_q, pos_q;
	logic [RW-1:0]    rs_q, re_q, row_q, sr_q, cur_r_q;
	logic [CW-1:0]    cs_q, ce_q, col_q, sc_q, cur_c_q;
	logic             vert_q, bad_q, parity_q;
	logic [AW:0]      sp_q;
	logic [1:0]       k_q;
	logic [AW-1:0]    nb_addr_q, clr_q;
	logic [COUNT_W-1:0] count_q;

	logic             out_valid_q, bad_line_q;
	logic [COUNT_W-1:0] open_regions_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic          cell_we, stk_we;
	logic [AW-1:0] cell_waddr, cell_raddr, stk_waddr, stk_raddr, stk_wdata;
	logic [1:0]    cell_wdata, cell_rdata;
	logic [AW-1:0] stk_rdata;

	logic [1:0]    mark;
	logic          cell_open, in_acc, bad_range, last_cell, nb_ok, draw_last, load_out;
	logic          col_wrap, scol_wrap, srow_last;
	logic [RW-1:0] nb_r;
	logic [CW-1:0] nb_c;

	// Register values of zero act as one, values above the maximum as the maximum.
	always_comb begin
		if (width_raw_q == '0) begin
			w = CFG_W'(1);
		end else if (9'(width_raw_q) > 9'(MAX_WIDTH)) begin
			w = CFG_W'(MAX_WIDTH);
		end else begin
			w = width_raw_q;
		end
		if (height_raw_q == '0) begin
			h = CFG_W'(1);
		end else if (9'(height_raw_q) > 9'(MAX_HEIGHT)) begin
			h = CFG_W'(MAX_HEIGHT);
		end else begin
			h = height_raw_q;
		end
	end

	assign total     = w * h;
	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign bad_range = (end_position < start_position) ||
		((2*CFG_W)'(end_position) >= total);

	assign mark      = {1'b1, parity_q};
	assign cell_open = (cell_rdata != CELL_WALL) && (cell_rdata != mark);

	assign scol_wrap = (9'(sc_q) + 9'd1) == 9'(w);
	assign srow_last = (9'(sr_q) + 9'd1) == 9'(h);
	assign last_cell = scol_wrap && srow_last;
	assign col_wrap  = (9'(col_q) + 9'd1) == 9'(w);
	assign draw_last = vert_q ? (row_q == re_q) : (pos_q == e_q);
	assign load_out  = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// The four neighbours in the order up, right, down, left.
	always_comb begin
		nb_r  = cur_r_q;
		nb_c  = cur_c_q;
		nb_ok = 1'b0;
		unique case (k_q)
			2'd0: begin
				nb_ok = (cur_r_q != '0);
				nb_r  = cur_r_q - RW'(1);
			end
			2'd1: begin
				nb_ok = (9'(cur_c_q) + 9'd1) < 9'(w);
				nb_c  = cur_c_q + CW'(1);
			end
			2'd2: begin
				nb_ok = (9'(cur_r_q) + 9'd1) < 9'(h);
				nb_r  = cur_r_q + RW'(1);
			end
			2'd3: begin
				nb_ok = (cur_c_q != '0);
				nb_c  = cur_c_q - CW'(1);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		cell_we          = 1'b0;
		cell_waddr       = {sr_q, sc_q};
		cell_wdata       = mark;
		cell_raddr       = {sr_q, sc_q};
		stk_we           = 1'b0;
		stk_waddr        = sp_q[AW-1:0];
		stk_wdata        = nb_addr_q;
		stk_raddr        = AW'(sp_q - (AW+1)'(1));
		div_req.start    = 1'b0;
		div_req.dividend = s_q;
		div_req.divisor  = w;
		unique case (state_q)
			ST_CLEAR: begin
				cell_we    = 1'b1;
				cell_waddr = clr_q;
				cell_wdata = CELL_EMPTY;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					state_d = bad_range ? ST_SCAN_RD : ST_DIV_S_GO;
				end
			end
			ST_DIV_S_GO: begin
				div_req.start = 1'b1;
				state_d       = ST_DIV_S_WAIT;
			end
			ST_DIV_S_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_DIV_E_GO;
				end
			end
			ST_DIV_E_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = e_q;
				state_d          = ST_DIV_E_WAIT;
			end
			ST_DIV_E_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				// A vertical line must keep its column.
				if (((e_q - s_q) >= POS_W'(w)) && (ce_q != cs_q)) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				cell_we    = 1'b1;
				cell_waddr = {row_q, col_q};
				cell_wdata = CELL_WALL;
				if (draw_last) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (cell_open) begin
					cell_we   = 1'b1;
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = {sr_q, sc_q};
					state_d   = ST_POP_RD;
				end else begin
					state_d = last_cell ? ST_FIN : ST_SCAN_RD;
				end
			end
			ST_POP_RD: begin
				if (sp_q == '0) begin
					state_d = last_cell ? ST_FIN : ST_SCAN_RD;
				end else begin
					state_d = ST_POP_WAIT;
				end
			end
			ST_POP_WAIT: begin
				state_d = ST_NB_SEL;
			end
			ST_NB_SEL: begin
				cell_raddr = {nb_r, nb_c};
				if (nb_ok) begin
					state_d = ST_NB_CHK;
				end else if (k_q == 2'd3) begin
					state_d = ST_POP_RD;
				end
			end
			ST_NB_CHK: begin
				if (cell_open) begin
					cell_we    = 1'b1;
					cell_waddr = nb_addr_q;
					stk_we     = 1'b1;
				end
				state_d = (k_q == 2'd3) ? ST_POP_RD : ST_NB_SEL;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_raw_q  <= CFG_W'(64);
			height_raw_q <= CFG_W'(64);
			parity_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			clr_q        <= '0;
			sp_q         <= '0;
			k_q          <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (reg_index_t'(cfg_index))
					REG_GRID_WIDTH:  width_raw_q  <= cfg_data;
					REG_GRID_HEIGHT: height_raw_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				parity_q    <= ~parity_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:     sp_q <= '0;
				ST_SCAN_CHK: if (cell_open) sp_q <= (AW+1)'(1);
				ST_POP_RD:   if (sp_q != '0) sp_q <= sp_q - (AW+1)'(1);
				ST_NB_CHK:   if (cell_open) sp_q <= sp_q + (AW+1)'(1);
				default: ;
			endcase
			if (state_q == ST_POP_WAIT) begin
				k_q <= '0;
			end else if ((state_q == ST_NB_SEL && !nb_ok) || state_q == ST_NB_CHK) begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				s_q     <= start_position;
				e_q     <= end_position;
				bad_q   <= bad_range;
				sr_q    <= '0;
				sc_q    <= '0;
				count_q <= '0;
			end
			ST_DIV_S_WAIT: begin
				rs_q <= RW'(div_rsp.quo);
				cs_q <= CW'(div_rsp.rem);
			end
			ST_DIV_E_WAIT: begin
				re_q <= RW'(div_rsp.quo);
				ce_q <= CW'(div_rsp.rem);
			end
			ST_DECIDE: begin
				row_q  <= rs_q;
				col_q  <= cs_q;
				pos_q  <= s_q;
				vert_q <= (e_q - s_q) >= POS_W'(w);
				if (((e_q - s_q) >= POS_W'(w)) && (ce_q != cs_q)) begin
					bad_q <= 1'b1;
				end
			end
			ST_DRAW: begin
				if (vert_q) begin
					row_q <= row_q + RW'(1);
				end else begin
					pos_q <= pos_q + POS_W'(1);
					if (col_wrap) begin
						col_q <= '0;
						row_q <= row_q + RW'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
			end
			ST_SCAN_CHK, ST_POP_RD: begin
				if (state_q == ST_SCAN_CHK && cell_open) begin
					count_q <= count_q + COUNT_W'(1);
				end else if ((state_q == ST_SCAN_CHK || sp_q == '0) && !last_cell) begin
					if (scol_wrap) begin
						sc_q <= '0;
						sr_q <= sr_q + RW'(1);
					end else begin
						sc_q <= sc_q + CW'(1);
					end
				end
			end
			ST_POP_WAIT: begin
				cur_r_q <= stk_rdata[AW-1:CW];
				cur_c_q <= stk_rdata[CW-1:0];
			end
			ST_NB_SEL: begin
				nb_addr_q <= {nb_r, nb_c};
			end
			default: ;
		endcase
		if (load_out) begin
			open_regions_q <= count_q;
			bad_line_q     <= bad_q;
		end
	end

	lcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lcr_ram #(
		.WIDTH (2),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	lcr_ram #(
		.WIDTH (AW),
		.DEPTH (CELLS)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign out_valid    = out_valid_q;
	assign open_regions = open_regions_q;
	assign bad_line     = bad_line_q;

endmodule
`default_nettype wire

[sim/lcr_checker.sv]
`timescale 1ns / 100ps
module lcr_checker
	import lcr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wen,
	input  wire logic               cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [POS_W-1:0]   start_position,
	input  wire logic [POS_W-1:0]   end_position,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [COUNT_W-1:0] open_regions,
	input  wire logic               bad_line,
	output int                      fail_count,
	output int                      pending_count,
	output int                      bad_seen
);
	localparam int GW = 64;
	localparam int GH = 64;
	localparam int CELLS = GW * GH;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               bad;
	} line_result_t;

	cell_t              grid [CELLS];
	int                 flood [CELLS];
	logic               parity;
	logic [CFG_W-1:0]   width_reg;
	logic [CFG_W-1:0]   height_reg;
	line_result_t       expected_q [$];

	function automatic int clamp_dim(input int v, input int m);
		if (v < 1) return 1;
		if (v > m) return m;
		return v;
	endfunction

	function automatic bit open_cell(input int a, input cell_t mk);
		return grid[a] != CELL_WALL && grid[a] != mk;
	endfunction

	// Draws the line unless it is malformed, then floods every open region with this line's marker.
	function automatic line_result_t draw_and_count(input int s, input int e);
		int w, h, stride, pos, cnt, sp, cur, cr, cc, n, a;
		int nb [4];
		bit bad;
		cell_t mk;
		line_result_t res;
		w = clamp_dim(width_reg, GW);
		h = clamp_dim(height_reg, GH);
		stride = 1;
		bad = 0;
		if (e < s || e >= w * h) begin
			bad = 1;
		end else if (e - s >= w) begin
			stride = w;
			if ((e - s) % w != 0) bad = 1;
		end
		if (!bad) begin
			pos = s;
			forever begin
				grid[(pos / w) * GW + (pos % w)] = CELL_WALL;
				if (pos == e) break;
				pos += stride;
			end
		end
		mk = parity ? CELL_MARK_B : CELL_MARK_A;
		cnt = 0;
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				a = r * GW + c;
				if (!open_cell(a, mk)) continue;
				cnt++;
				grid[a] = mk;
				sp = 0;
				flood[sp] = a;
				sp++;
				while (sp > 0) begin
					sp--;
					cur = flood[sp];
					cr = cur / GW;
					cc = cur % GW;
					n = 0;
					if (cr > 0) begin
						nb[n] = cur - GW;
						n++;
					end
					if (cc + 1 < w) begin
						nb[n] = cur + 1;
						n++;
					end
					if (cr + 1 < h) begin
						nb[n] = cur + GW;
						n++;
					end
					if (cc > 0) begin
						nb[n] = cur - 1;
						n++;
					end
					for (int k = 0; k < n; k++) begin
						if (open_cell(nb[k], mk)) begin
							grid[nb[k]] = mk;
							flood[sp] = nb[k];
							sp++;
						end
					end
				end
			end
		end
		parity = ~parity;
		res.count = COUNT_W'(cnt);
		res.bad = bad;
		return res;
	endfunction

	assign pending_count = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		line_result_t exp_r;
		if (!arst_n) begin
			foreach (grid[i]) grid[i] = CELL_EMPTY;
			parity = 0;
			width_reg = CFG_W'(64);
			height_reg = CFG_W'(64);
			expected_q.delete();
			fail_count = 0;
			bad_seen = 0;
		end else begin
			// Results are checked before this edge's new line is predicted.
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result beat with no line waiting: count %0d", open_regions);
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (open_regions !== exp_r.count) begin
						$error("open_regions: expected %0d, actual %0d", exp_r.count,
							open_regions);
						fail_count++;
					end
					if (bad_line !== exp_r.bad) begin
						$error("bad_line: expected %0d, actual %0d", exp_r.bad, bad_line);
						fail_count++;
					end
				end
			end
			if (cfg_wen) begin
				if (cfg_index == REG_GRID_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
			end
			if (in_valid && !in_stall) begin
				exp_r = draw_and_count(start_position, end_position);
				if (exp_r.bad) bad_seen++;
				expected_q.push_back(exp_r);
			end
		end
	end
endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
module tb;
	import lcr_pkg::*;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_wen = 0;
	logic               cfg_index = 0;
	logic [CFG_W-1:0]   cfg_data = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic [POS_W-1:0]   start_position = 0;
	logic [POS_W-1:0]   end_position = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic [COUNT_W-1:0] open_regions;
	logic               bad_line;
	int                 fail_count, pending_count, bad_seen;
	int                 lines_sent = 0;
	int                 settings_used = 0;
	int                 cur_w = 64, cur_h = 64;
	bit                 quiet = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	line_draw_region_counter u_dut (.*);
	lcr_checker u_chk (.*);

	// The receiver stalls in random bursts until the quiet final stretch.
	initial begin
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	// Register writes happen only with the block idle: the input is dropped
	// first, and every result must be in before the write.
	task automatic write_dims(input int w, input int h);
		in_valid <= 0;
		@(posedge clk);
		wait (pending_count == 0);
		@(posedge clk);
		cfg_wen <= 1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(posedge clk);
		cfg_wen <= 0;
		cur_w = (w < 1) ? 1 : (w > 64 ? 64 : w);
		cur_h = (h < 1) ? 1 : (h > 64 ? 64 : h);
		settings_used++;
	endtask

	// One input beat: valid is held until the block takes it, then an
	// optional idle burst follows.
	task automatic send_line(input int s, input int e);
		in_valid <= 1;
		start_position <= POS_W'(s);
		end_position <= POS_W'(e);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		lines_sent++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end else if (!quiet && $urandom_range(0, 1) == 0) begin
			in_valid <= 0;
		end
	endtask

	// Mostly well-formed lines: horizontal runs and vertical strokes inside
	// the canvas, with some malformed or random beats mixed in.
	task automatic random_line();
		int total, s, len, kind;
		total = cur_w * cur_h;
		kind = $urandom_range(0, 9);
		s = $urandom_range(0, total - 1);
		if (kind < 4) begin
			len = $urandom_range(0, cur_w);
			send_line(s, (s + len >= total) ? total - 1 : s + len);
		end else if (kind < 8) begin
			len = $urandom_range(0, cur_h - 1 - s / cur_w);
			send_line(s, s + len * cur_w);
		end else begin
			send_line($urandom_range(0, 4095), $urandom_range(0, 4095));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed lines on the full reset canvas.
		send_line(0, 0);
		send_line(4095, 4095);
		send_line(64, 127);
		send_line(5, 5 + 64 * 63);
		send_line(10, 9);
		send_line(0, 4095);
		send_line(3, 3 + 64 * 2 + 1);
		send_line(2000, 2010);
		// A one-cell canvas from out-of-range zero settings.
		write_dims(0, 0);
		send_line(0, 0);
		send_line(0, 1);
		// Oversized settings clamp to the maximum.
		write_dims(127, 127);
		send_line(130, 130 + 64 * 10);
		// A small canvas where horizontal runs wrap across row ends.
		write_dims(5, 4);
		send_line(3, 7);
		send_line(1, 16);
		send_line(2, 4);
		send_line(0, 20);
		send_line(4095, 0);
		write_dims(1, 64);
		send_line(0, 63);
		send_line(10, 20);
		write_dims(64, 1);
		send_line(0, 63);
		send_line(20, 20);
		// Random part over several small canvases, one wide setting last.
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) write_dims(64, 64);
			else write_dims($urandom_range(1, 16), $urandom_range(1, 16));
			if (ph == 4) quiet = 1;
			for (int i = 0; i < 14; i++) random_line();
			if (ph == 2) begin
				in_valid <= 0;
				@(posedge clk);
				wait (pending_count == 0);
				@(posedge clk);
			end
		end
		in_valid <= 0;
		@(posedge clk);
		wait (pending_count == 0);
		repeat (20000) @(posedge clk);
		$display("Drove %0d lines over %0d canvas settings, %0d of them malformed.",
			lines_sent, settings_used, bad_seen);
		if (fail_count == 0 && pending_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("simulation failed");
		$finish;
	end
endmodule
